// File: rtl/core/edc_pkg.sv
`default_nettype none

package edc_pkg;

    localparam int CENTER_W = 16;
    localparam int COEF_W   = 24;
    localparam int DX_W     = CENTER_W + 1;
    localparam int PROD_W   = COEF_W + DX_W;
    localparam int Q_W      = PROD_W + 1;
    localparam int MAG_W    = 26;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int RAD_W    = 20;
    localparam int RAD_LSB  = 32;
    localparam int ROOT_W   = 10;
    localparam int REM_W    = ROOT_W + 2;
    localparam int DIST_W   = 10;
    localparam int CFG_IDX_W = 3;

    localparam int SQRT_STAGES = ROOT_W / 2;

    localparam logic [MAG_W-1:0]  LIMIT_Q24     = MAG_W'(3) << 24;
    localparam logic [SQ_W-1:0]   LIMIT_SQ48    = SQ_W'(9) << 48;
    localparam logic [DIST_W-1:0] OVERFLOW_CODE = DIST_W'(819);
    localparam logic [DIST_W-1:0] DIST_LIMIT    = DIST_W'(768);
    localparam logic [COEF_W-1:0] COEF_ONE      = COEF_W'(1) << 20;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY  = 3'd5;

    // request into the root pipeline
    typedef struct packed {
        logic             over;
        logic [RAD_W-1:0] rad;
    } sq_req_t;

    typedef struct packed {
        logic              over;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_stage_t;

    // one digit of the restoring square root, top radicand pair first
    function automatic sq_stage_t sqrt_step(input sq_stage_t s);
        sq_stage_t        r;
        logic [REM_W+1:0] rs;
        logic [REM_W+1:0] trial;
        r     = s;
        rs    = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = (REM_W + 2)'({s.root, 2'b01});
        r.rad = s.rad << 2;
        if (rs >= trial) begin
            r.rem  = REM_W'(rs - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = REM_W'(rs);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/edc_sqrt.sv
`default_nettype none

module edc_sqrt (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  edc_pkg::sq_req_t        in_req,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [edc_pkg::DIST_W-1:0]    out_distance
);

    localparam int N = edc_pkg::SQRT_STAGES;

    edc_pkg::sq_stage_t st_reg [N];
    edc_pkg::sq_stage_t st_in  [N];
    logic [N-1:0]       vld_reg;
    logic [N-1:0]       en;

    always_comb begin
        en[N-1] = !vld_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_comb begin
        st_in[0].over = in_req.over;
        st_in[0].rad  = in_req.rad;
        st_in[0].rem  = '0;
        st_in[0].root = '0;
        for (int k = 1; k < N; k++) begin
            st_in[k] = st_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (en[k]) begin
                st_reg[k] <= edc_pkg::sqrt_step(edc_pkg::sqrt_step(st_in[k]));
            end
        end
    end

    assign out_valid    = vld_reg[N-1];
    assign out_distance = st_reg[N-1].over ? edc_pkg::OVERFLOW_CODE : st_reg[N-1].root;

endmodule

`default_nettype wire

// File: rtl/core/elliptical_distance_clamp.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_point_x[15:0], s_point_y[15:0]
// m_        out        m_valid / m_ready      m_distance[9:0]
// cfg_      in         cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[23:0]
//
// One point per cycle unless the output stalls. Stages: offset, products, sums,
// magnitude, squares, squared sum, then five root stages of two digits each.
// Synchronous active-low reset empties the pipeline and loads the identity matrix.
// Each stage holds while the next is full and stalled; empty stages fill regardless.
// Config is always ready.
`default_nettype none

module elliptical_distance_clamp (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [edc_pkg::CENTER_W-1:0]        s_point_x,
    input  wire  [edc_pkg::CENTER_W-1:0]        s_point_y,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [edc_pkg::DIST_W-1:0]          m_distance,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [edc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [edc_pkg::COEF_W-1:0]          cfg_data
);

    localparam int NS = 6;

    logic [edc_pkg::CENTER_W-1:0]     center_x_reg, center_y_reg;
    logic signed [edc_pkg::COEF_W-1:0] coef_xx_reg, coef_xy_reg, coef_yx_reg, coef_yy_reg;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    logic          sq_ready;

    logic signed [edc_pkg::DX_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [edc_pkg::PROD_W-1:0] p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    logic signed [edc_pkg::PROD_W-1:0] p_xx_next, p_xy_next, p_yx_next, p_yy_next;
    logic signed [edc_pkg::Q_W-1:0]    q1_reg, q2_reg, q1_next, q2_next;
    logic [edc_pkg::Q_W-1:0]           mag1, mag2;
    logic [edc_pkg::MAG_W-1:0]         a1_reg, a2_reg;
    logic                              over_a_reg, over_a_next;
    logic [edc_pkg::SQ_W-1:0]          sq1_reg, sq2_reg, sq1_next, sq2_next;
    logic                              over_b_reg;
    logic [edc_pkg::SUM_W-1:0]         sum;
    edc_pkg::sq_req_t                  req_reg, req_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            coef_xx_reg  <= edc_pkg::COEF_ONE;
            coef_xy_reg  <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= edc_pkg::COEF_ONE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                edc_pkg::CFG_CENTER_X: begin
                    center_x_reg <= cfg_data[edc_pkg::CENTER_W-1:0];
                end
                edc_pkg::CFG_CENTER_Y: begin
                    center_y_reg <= cfg_data[edc_pkg::CENTER_W-1:0];
                end
                edc_pkg::CFG_COEF_XX: coef_xx_reg <= cfg_data;
                edc_pkg::CFG_COEF_XY: coef_xy_reg <= cfg_data;
                edc_pkg::CFG_COEF_YX: coef_yx_reg <= cfg_data;
                edc_pkg::CFG_COEF_YY: coef_yy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || sq_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb begin
        dx_next = $signed({1'b0, s_point_x}) - $signed({1'b0, center_x_reg});
        dy_next = $signed({1'b0, s_point_y}) - $signed({1'b0, center_y_reg});

        p_xx_next = edc_pkg::PROD_W'(coef_xx_reg) * edc_pkg::PROD_W'(dx_reg);
        p_xy_next = edc_pkg::PROD_W'(coef_xy_reg) * edc_pkg::PROD_W'(dy_reg);
        p_yx_next = edc_pkg::PROD_W'(coef_yx_reg) * edc_pkg::PROD_W'(dx_reg);
        p_yy_next = edc_pkg::PROD_W'(coef_yy_reg) * edc_pkg::PROD_W'(dy_reg);

        q1_next = edc_pkg::Q_W'(p_xx_reg) + edc_pkg::Q_W'(p_xy_reg);
        q2_next = edc_pkg::Q_W'(p_yx_reg) + edc_pkg::Q_W'(p_yy_reg);

        mag1 = q1_reg[edc_pkg::Q_W-1] ? edc_pkg::Q_W'(-q1_reg) : edc_pkg::Q_W'(q1_reg);
        mag2 = q2_reg[edc_pkg::Q_W-1] ? edc_pkg::Q_W'(-q2_reg) : edc_pkg::Q_W'(q2_reg);
        over_a_next = (mag1 > edc_pkg::Q_W'(edc_pkg::LIMIT_Q24))
                   || (mag2 > edc_pkg::Q_W'(edc_pkg::LIMIT_Q24));

        sq1_next = edc_pkg::SQ_W'(a1_reg) * edc_pkg::SQ_W'(a1_reg);
        sq2_next = edc_pkg::SQ_W'(a2_reg) * edc_pkg::SQ_W'(a2_reg);

        sum = edc_pkg::SUM_W'(sq1_reg) + edc_pkg::SUM_W'(sq2_reg);
        req_next.over = over_b_reg || (sum > edc_pkg::SUM_W'(edc_pkg::LIMIT_SQ48));
        req_next.rad  = sum[edc_pkg::RAD_LSB +: edc_pkg::RAD_W];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en[1]) begin
            p_xx_reg <= p_xx_next;
            p_xy_reg <= p_xy_next;
            p_yx_reg <= p_yx_next;
            p_yy_reg <= p_yy_next;
        end
        if (en[2]) begin
            q1_reg <= q1_next;
            q2_reg <= q2_next;
        end
        if (en[3]) begin
            a1_reg     <= mag1[edc_pkg::MAG_W-1:0];
            a2_reg     <= mag2[edc_pkg::MAG_W-1:0];
            over_a_reg <= over_a_next;
        end
        if (en[4]) begin
            sq1_reg    <= sq1_next;
            sq2_reg    <= sq2_next;
            over_b_reg <= over_a_reg;
        end
        if (en[5]) begin
            req_reg <= req_next;
        end
    end

    edc_sqrt u_sqrt (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (vld_reg[NS-1]),
        .in_ready     (sq_ready),
        .in_req       (req_reg),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_distance (m_distance)
    );

`ifndef SYNTHESIS
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_distance != edc_pkg::OVERFLOW_CODE) |-> (m_distance <= edc_pkg::DIST_LIMIT))
        else $error("distance above limit without overflow code");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output side can drain");

    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import edc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [DIST_W-1:0]    DIST_OVERFLOW = 10'd819;
    localparam longint AXIS_LIMIT   = longint'(3) << 24;
    localparam longint SQUARE_LIMIT = longint'(9) << 48;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_POINTS   = 90;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [CENTER_W-1:0]  s_point_x = '0;
    logic [CENTER_W-1:0]  s_point_y = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [DIST_W-1:0]    m_distance;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data  = '0;

    // register image
    logic [15:0]        ctr_x = '0;
    logic [15:0]        ctr_y = '0;
    logic signed [23:0] k_xx  = 24'sd1048576;
    logic signed [23:0] k_xy  = '0;
    logic signed [23:0] k_yx  = '0;
    logic signed [23:0] k_yy  = 24'sd1048576;

    logic [DIST_W-1:0] expected_dist [$];
    logic [DIST_W-1:0] want_dist;
    int errors          = 0;
    int checked         = 0;
    int reg_writes      = 0;
    int settings_loaded = 0;
    int cycles          = 0;
    bit rx_stalls       = 1'b0;
    bit rx_hold         = 1'b0;

    elliptical_distance_clamp u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_point_x  (s_point_x),
        .s_point_y  (s_point_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d distances still pending", $time, expected_dist.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [DIST_W-1:0] ellipse_distance(input logic [15:0] px,
                                                           input logic [15:0] py);
        longint      dx, dy, q1, q2, a1, a2, sq;
        int unsigned rad, root, trial;
        dx = longint'(px) - longint'(ctr_x);
        dy = longint'(py) - longint'(ctr_y);
        q1 = longint'(k_xx) * dx + longint'(k_xy) * dy;
        q2 = longint'(k_yx) * dx + longint'(k_yy) * dy;
        a1 = (q1 < 0) ? -q1 : q1;
        a2 = (q2 < 0) ? -q2 : q2;
        if (a1 > AXIS_LIMIT || a2 > AXIS_LIMIT)
            return DIST_OVERFLOW;
        sq = a1 * a1 + a2 * a2;
        if (sq > SQUARE_LIMIT)
            return DIST_OVERFLOW;
        rad  = 32'(sq >>> 32);
        root = 0;
        for (int b = 9; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= rad)
                root = trial;
        end
        return DIST_W'(root);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [23:0] rand_coef(input int e);
        int span;
        span = 1 << e;
        return 24'(int'($urandom_range(0, 2 * span - 1)) - span);
    endfunction

    // offset radius (Q4 counts) that keeps most lengths near the 3.0 boundary
    function automatic int near_radius();
        longint r1, r2, ksum, r;
        r1 = (k_xx < 0 ? -longint'(k_xx) : longint'(k_xx)) +
             (k_xy < 0 ? -longint'(k_xy) : longint'(k_xy));
        r2 = (k_yx < 0 ? -longint'(k_yx) : longint'(k_yx)) +
             (k_yy < 0 ? -longint'(k_yy) : longint'(k_yy));
        ksum = (r1 > r2) ? r1 : r2;
        if (ksum < (1 << 14))
            ksum = 1 << 14;
        r = (longint'(56) << 20) / ksum;
        if (r < 1)
            r = 1;
        if (r > 65535)
            r = 65535;
        return int'(r);
    endfunction

    function automatic logic [15:0] near_coord(input logic [15:0] c, input int radius);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * radius)) - radius;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    function automatic logic [31:0] pick_point(input int radius);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return {near_coord(ctr_x, radius), near_coord(ctr_y, radius)};
        if (sel == 7)
            return {($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000,
                    ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000};
        return $urandom();
    endfunction

    task automatic send_point(input logic [15:0] px, input logic [15:0] py);
        s_valid   <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        do @(posedge aclk); while (!s_ready);
        expected_dist.push_back(ellipse_distance(px, py));
        @(negedge aclk);
    endtask

    task automatic idle_input(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_dist.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CENTER_X: ctr_x = data[15:0];
            CFG_CENTER_Y: ctr_y = data[15:0];
            CFG_COEF_XX:  k_xx  = data;
            CFG_COEF_XY:  k_xy  = data;
            CFG_COEF_YX:  k_yx  = data;
            CFG_COEF_YY:  k_yy  = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_setting(input logic [15:0] cx, input logic [15:0] cy,
                                input logic signed [23:0] kxx, input logic signed [23:0] kxy,
                                input logic signed [23:0] kyx, input logic signed [23:0] kyy);
        wait_for_results();
        write_register(CFG_CENTER_X, {8'($urandom()), cx});
        write_register(CFG_CENTER_Y, {8'($urandom()), cy});
        write_register(CFG_COEF_XX, kxx);
        write_register(CFG_COEF_XY, kxy);
        write_register(CFG_COEF_YX, kyx);
        write_register(CFG_COEF_YY, kyy);
        settings_loaded++;
    endtask

    // values after reset: unit matrix, center at origin
    task automatic test_reset_identity();
        send_point(16'd0, 16'd0);
        send_point(16'd48, 16'd0);
        send_point(16'd49, 16'd0);
        send_point(16'd0, 16'd48);
        send_point(16'd0, 16'd49);
        send_point(16'd16, 16'd16);
        send_point(16'd33, 16'd33);
        send_point(16'd34, 16'd34);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h0000, 16'hFFFF);
        send_point(16'hFFFF, 16'h0000);
    endtask

    // upper data bits on center writes, writes to unused indexes
    task automatic test_register_masking();
        wait_for_results();
        write_register(CFG_CENTER_X, 24'hFF0030);
        write_register(CFG_CENTER_Y, 24'h5A0030);
        write_register(CFG_SPARE_LO, 24'h000000);
        write_register(CFG_SPARE_HI, 24'hFFFFFF);
        send_point(16'd48, 16'd48);
        send_point(16'd0, 16'd48);
        send_point(16'd96, 16'd48);
        send_point(16'd48, 16'd97);
        send_point(16'd0, 16'd0);
        send_point(16'd60, 16'd56);
    endtask

    task automatic test_coef_extremes();
        load_setting(16'd0, 16'd0, -24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608);
        send_point(16'd1, 16'd0);
        send_point(16'd0, 16'd1);
        send_point(16'd1, 16'd1);
        send_point(16'd2, 16'd3);
        send_point(16'hFFFF, 16'd0);
        send_point(16'd0, 16'hFFFF);
        load_setting(16'hFFFF, 16'hFFFF, COEF_W'(1) << 20, 24'sd0, 24'sd0, COEF_W'(1) << 20);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'hFFCF, 16'hFFFF);
    endtask

    // output held off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        int radius;
        load_setting(16'($urandom()), 16'($urandom()), 24'sd1048576, 24'sd262144,
                     -24'sd131072, 24'sd786432);
        radius = near_radius();
        @(posedge aclk);
        rx_hold = 1'b1;
        @(negedge aclk);
        for (int i = 0; i < 60; i++) begin
            logic [31:0] pt;
            pt = pick_point(radius);
            send_point(pt[31:16], pt[15:0]);
        end
        wait_for_results();
    endtask

    task automatic test_random_settings();
        logic [15:0]        cx, cy;
        logic signed [23:0] k [4];
        logic [31:0]        pt;
        int                 e, radius, mode;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            cx = $urandom();
            cy = $urandom();
            case (ph)
                0: begin
                    cx = '1;
                    cy = '1;
                    foreach (k[i]) k[i] = 24'sd8388607;
                end
                1: begin
                    cx = '0;
                    cy = '0;
                    foreach (k[i]) k[i] = -24'sd8388608;
                end
                2: foreach (k[i]) k[i] = '0;
                3: begin
                    k[0] = 24'sd1048576;
                    k[1] = '0;
                    k[2] = '0;
                    k[3] = 24'sd1048576;
                end
                default: begin
                    e = $urandom_range(14, 23);
                    foreach (k[i]) k[i] = ($urandom_range(0, 5) == 0) ? 24'sd0 : rand_coef(e);
                end
            endcase
            load_setting(cx, cy, k[0], k[1], k[2], k[3]);
            radius    = near_radius();
            mode      = ph % 4;
            rx_stalls = (mode >= 2);
            for (int i = 0; i < PHASE_POINTS; i++) begin
                if (mode == 1 && i == PHASE_POINTS / 2)
                    wait_for_results();
                pt = pick_point(radius);
                send_point(pt[31:16], pt[15:0]);
                if ((mode == 1 || mode == 3) && $urandom_range(0, 3) == 0)
                    idle_input(pick_gap());
            end
        end
        rx_stalls = 1'b0;
    endtask

    // result sink
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge aclk);
                rx_hold = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_dist.size() == 0) begin
                $display("%0t: unexpected distance, expected none, actual %0d",
                         $time, m_distance);
                errors++;
            end else begin
                want_dist = expected_dist.pop_front();
                if (m_distance !== want_dist) begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, want_dist, m_distance);
                    errors++;
                end
                checked++;
            end
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_identity();
        test_register_masking();
        test_coef_extremes();
        test_backpressure();
        test_random_settings();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("summary: %0d distances checked, %0d register writes, %0d settings",
                 checked, reg_writes, settings_loaded);
        $display("summary: field and coefficient extremes, masked and spare writes, long hold");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/edc_pkg.sv
rtl/core/edc_sqrt.sv
rtl/core/elliptical_distance_clamp.sv
tb/tb.sv
